### hdl/sts_pkg.sv
// Shared types and constants for the sorted table interval search block.
// Used by sts_core and sorted_table_interval_search; has no dependencies.
`timescale 1ns / 1ps

package sts_pkg;

  localparam int IDX_W     = 10;
  localparam int OUT_IDX_W = 11;
  localparam int IN_VAL_W  = 32;

  localparam logic FUNC_WRITE  = 1'b0;
  localparam logic FUNC_SEARCH = 1'b1;

  // Start of one item, from the input side to the sequencer.
  typedef struct packed {
    logic             start;
    logic             func;
    logic [IDX_W-1:0] lo;
    logic [IDX_W-1:0] hi;
  } sts_req_t;

  // Table read request issued by the sequencer.
  typedef struct packed {
    logic             en;
    logic [IDX_W-1:0] idx;
  } sts_rd_t;

  // Finished result held by the sequencer until the output register takes it.
  typedef struct packed {
    logic                 valid;
    logic                 is_search;
    logic                 bad;
    logic                 below;
    logic                 above;
    logic [OUT_IDX_W-1:0] idx;
  } sts_res_t;

endpackage

### hdl/sts_ram.sv
// Generic single-clock RAM with one write port and one registered read port.
// No dependencies.
`timescale 1ns / 1ps

module sts_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 1024
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

### hdl/sts_core.sv
// Search sequencer: bound checks and bisection, one table read per cycle
// through a single shared key comparator. Depends on sts_pkg.
`timescale 1ns / 1ps

module sts_core
  import sts_pkg::*;
#(
  parameter int VALUE_WIDTH = 32
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  sts_req_t                      req_i,
  input  logic signed [VALUE_WIDTH-1:0] key_i,
  output sts_rd_t                       rd_o,
  input  logic signed [VALUE_WIDTH-1:0] rd_val_i,
  output sts_res_t                      res_o,
  input  logic                          res_ack_i,
  output logic                          idle_o
);

  localparam logic [2:0] ST_IDLE    = 3'd0;
  localparam logic [2:0] ST_RD_LO   = 3'd1;
  localparam logic [2:0] ST_CMP_LO  = 3'd2;
  localparam logic [2:0] ST_CMP_HI  = 3'd3;
  localparam logic [2:0] ST_CMP_MID = 3'd4;
  localparam logic [2:0] ST_DONE    = 3'd5;

  logic [2:0]                    state_q, state_d;
  logic signed [VALUE_WIDTH-1:0] key_q, key_d;
  logic [IDX_W-1:0]              lo_q, lo_d;
  logic [IDX_W-1:0]              hi_q, hi_d;
  logic [IDX_W-1:0]              mid_q, mid_d;
  sts_res_t                      info_q, info_d;

  logic             key_lt;
  logic [IDX_W:0]   sum_lh;
  logic [IDX_W-1:0] mid_lh;
  logic [IDX_W-1:0] step_lo;
  logic [IDX_W-1:0] step_hi;
  logic [IDX_W:0]   step_sum;
  logic [IDX_W-1:0] step_mid;

  // The one comparator: key against whatever entry was read last cycle.
  assign key_lt = key_q < rd_val_i;

  assign sum_lh = {1'b0, lo_q} + {1'b0, hi_q};
  assign mid_lh = sum_lh[IDX_W:1];

  // Narrow the interval by the entry at mid, then form the next midpoint.
  always_comb begin
    step_lo = lo_q;
    step_hi = hi_q;
    if (key_lt) begin
      step_hi = mid_q;
    end else begin
      step_lo = mid_q;
    end
  end

  assign step_sum = {1'b0, step_lo} + {1'b0, step_hi};
  assign step_mid = step_sum[IDX_W:1];

  always_comb begin
    state_d = state_q;
    key_d   = key_q;
    lo_d    = lo_q;
    hi_d    = hi_q;
    mid_d   = mid_q;
    info_d  = info_q;
    rd_o    = '0;
    unique case (state_q)
      ST_IDLE: begin
        if (req_i.start) begin
          key_d  = key_i;
          lo_d   = req_i.lo;
          hi_d   = req_i.hi;
          info_d = '0;
          if (req_i.func == FUNC_WRITE) begin
            state_d = ST_DONE;
          end else if (req_i.hi <= req_i.lo) begin
            info_d.is_search = 1'b1;
            info_d.bad       = 1'b1;
            state_d          = ST_DONE;
          end else begin
            info_d.is_search = 1'b1;
            state_d          = ST_RD_LO;
          end
        end
      end
      ST_RD_LO: begin
        rd_o.en  = 1'b1;
        rd_o.idx = lo_q;
        state_d  = ST_CMP_LO;
      end
      ST_CMP_LO: begin
        if (key_lt) begin
          info_d.below = 1'b1;
          info_d.idx   = {1'b0, lo_q} - OUT_IDX_W'(1);
          state_d      = ST_DONE;
        end else begin
          rd_o.en  = 1'b1;
          rd_o.idx = hi_q;
          state_d  = ST_CMP_HI;
        end
      end
      ST_CMP_HI: begin
        if (!key_lt) begin
          info_d.above = 1'b1;
          info_d.idx   = {1'b0, hi_q};
          state_d      = ST_DONE;
        end else if (mid_lh == lo_q) begin
          info_d.idx = {1'b0, lo_q};
          state_d    = ST_DONE;
        end else begin
          rd_o.en  = 1'b1;
          rd_o.idx = mid_lh;
          mid_d    = mid_lh;
          state_d  = ST_CMP_MID;
        end
      end
      ST_CMP_MID: begin
        lo_d = step_lo;
        hi_d = step_hi;
        if (step_mid == step_lo) begin
          info_d.idx = {1'b0, step_mid};
          state_d    = ST_DONE;
        end else begin
          rd_o.en  = 1'b1;
          rd_o.idx = step_mid;
          mid_d    = step_mid;
        end
      end
      ST_DONE: begin
        if (res_ack_i) begin
          state_d = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_ff @(posedge clk_i) begin
    key_q  <= key_d;
    lo_q   <= lo_d;
    hi_q   <= hi_d;
    mid_q  <= mid_d;
    info_q <= info_d;
  end

  always_comb begin
    res_o       = info_q;
    res_o.valid = (state_q == ST_DONE);
  end

  assign idle_o = (state_q == ST_IDLE);

endmodule

### hdl/sorted_table_interval_search.sv
// Top level of the sorted table interval search: handshakes, table memory,
// index range checks and output register. Depends on sts_pkg, sts_ram, sts_core.
//
//   channel | direction | handshake              | payload
//   input   | in        | in_valid_i/in_ready_o  | func, entry_index, entry_value,
//           |           |                        | search_key, low_bound, high_bound
//   output  | out       | out_valid_o/out_ready_i| interval_index, below_range,
//           |           |                        | above_range, bad_bounds, is_search
//
// A write item, or a search with bad bounds, goes straight to the done state.
// Other searches compare the key with the low bound entry, then the high bound
// entry, stopping if the key is out of range, then bisect: one read of the single
// table memory port per cycle, each feeding the shared key comparator.
// One item is worked on at a time; the next is taken while a result waits in the
// output register. Reset clears control state only; the table holds no valid bits.
`timescale 1ns / 1ps

module sorted_table_interval_search
  import sts_pkg::*;
#(
  parameter int TABLE_DEPTH = 1024,
  parameter int VALUE_WIDTH = 32
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        in_valid_i,
  output logic                        in_ready_o,
  input  logic                        func_i,
  input  logic [IDX_W-1:0]            entry_index_i,
  input  logic signed [IN_VAL_W-1:0]  entry_value_i,
  input  logic signed [IN_VAL_W-1:0]  search_key_i,
  input  logic [IDX_W-1:0]            low_bound_i,
  input  logic [IDX_W-1:0]            high_bound_i,
  output logic                        out_valid_o,
  input  logic                        out_ready_i,
  output logic signed [OUT_IDX_W-1:0] interval_index_o,
  output logic                        below_range_o,
  output logic                        above_range_o,
  output logic                        bad_bounds_o,
  output logic                        is_search_o
);

  localparam int AW    = $clog2(TABLE_DEPTH);
  localparam int EXT_W = (AW > IDX_W) ? AW : IDX_W;

  logic in_xfer;
  logic core_idle;

  sts_req_t req;
  sts_rd_t  rd;
  sts_res_t res;
  logic     res_load;

  logic signed [63:0]            value_ext;
  logic signed [63:0]            key_ext;
  logic signed [VALUE_WIDTH-1:0] key_w;
  logic [VALUE_WIDTH-1:0]        ram_rdata;
  logic signed [VALUE_WIDTH-1:0] rd_val;

  logic [EXT_W-1:0] wr_ext;
  logic [EXT_W-1:0] rd_ext;
  logic             wr_in_range;
  logic             rd_in_range;
  logic             ram_we;
  logic             oor_q;

  logic                 out_valid_q, out_valid_d;
  logic [OUT_IDX_W-1:0] out_idx_q;
  logic                 out_below_q;
  logic                 out_above_q;
  logic                 out_bad_q;
  logic                 out_search_q;

  assign in_ready_o = core_idle;
  assign in_xfer    = in_valid_i & in_ready_o;

  // Incoming values are sign-extended, then wrapped to the table width.
  assign value_ext = entry_value_i;
  assign key_ext   = search_key_i;
  assign key_w     = key_ext[VALUE_WIDTH-1:0];

  // Indices past the table depth: writes are dropped, reads return zero.
  assign wr_ext      = EXT_W'(entry_index_i);
  assign rd_ext      = EXT_W'(rd.idx);
  assign wr_in_range = {1'b0, wr_ext} < (EXT_W + 1)'(TABLE_DEPTH);
  assign rd_in_range = {1'b0, rd_ext} < (EXT_W + 1)'(TABLE_DEPTH);
  assign ram_we      = in_xfer && (func_i == FUNC_WRITE) && wr_in_range;

  sts_ram #(
    .WIDTH (VALUE_WIDTH),
    .DEPTH (TABLE_DEPTH)
  ) u_table (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (wr_ext[AW-1:0]),
    .wdata_i (value_ext[VALUE_WIDTH-1:0]),
    .re_i    (rd.en),
    .raddr_i (rd_ext[AW-1:0]),
    .rdata_o (ram_rdata)
  );

  always_ff @(posedge clk_i) begin
    if (rd.en) begin
      oor_q <= !rd_in_range;
    end
  end

  assign rd_val = oor_q ? '0 : $signed(ram_rdata);

  always_comb begin
    req.start = in_xfer;
    req.func  = func_i;
    req.lo    = low_bound_i;
    req.hi    = high_bound_i;
  end

  sts_core #(
    .VALUE_WIDTH (VALUE_WIDTH)
  ) u_core (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .req_i     (req),
    .key_i     (key_w),
    .rd_o      (rd),
    .rd_val_i  (rd_val),
    .res_o     (res),
    .res_ack_i (res_load),
    .idle_o    (core_idle)
  );

  // The output register takes a result whenever it is empty or being drained.
  assign res_load    = res.valid && (!out_valid_q || out_ready_i);
  assign out_valid_d = res_load || (out_valid_q && !out_ready_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (res_load) begin
      out_idx_q    <= res.idx;
      out_below_q  <= res.below;
      out_above_q  <= res.above;
      out_bad_q    <= res.bad;
      out_search_q <= res.is_search;
    end
  end

  assign out_valid_o      = out_valid_q;
  assign interval_index_o = $signed(out_idx_q);
  assign below_range_o    = out_below_q;
  assign above_range_o    = out_above_q;
  assign bad_bounds_o     = out_bad_q;
  assign is_search_o      = out_search_q;

endmodule

### tb/sv/sorted_table_interval_search_tb.sv
// Self-checking testbench for sorted_table_interval_search: directed table, then random runs.
// Predicts every answer from its own copy of the table. Needs sts_pkg and the block's RTL.
`timescale 1ns / 1ps

module sorted_table_interval_search_tb;
  import sts_pkg::*;

  localparam int TABLE_DEPTH     = 1024;
  localparam int ITEM_TARGET     = 850;
  localparam int CALM_ITEMS      = 100;
  localparam int HOLD_OFF_CYCLES = 300;
  localparam int DIRECTED_COUNT  = 23;
  localparam logic signed [IN_VAL_W-1:0] VAL_MIN = 32'sh8000_0000;
  localparam logic signed [IN_VAL_W-1:0] VAL_MAX = 32'sh7fff_ffff;

  typedef struct packed {
    logic                       func;
    logic [IDX_W-1:0]           entry_index;
    logic signed [IN_VAL_W-1:0] entry_value;
    logic signed [IN_VAL_W-1:0] search_key;
    logic [IDX_W-1:0]           low_bound;
    logic [IDX_W-1:0]           high_bound;
  } lookup_item_t;

  typedef struct packed {
    logic signed [OUT_IDX_W-1:0] found_index;
    logic                        below;
    logic                        above;
    logic                        bad;
    logic                        is_search;
  } lookup_answer_t;

  typedef struct packed {
    lookup_item_t   item;
    logic           typed;
    lookup_answer_t answer;
  } directed_row_t;

  localparam lookup_answer_t WRITE_ACK  = '0;
  localparam lookup_answer_t BAD_BOUNDS = '{'0, 1'b0, 1'b0, 1'b1, 1'b1};

  logic                        clk_i         = 1'b0;
  logic                        rst_ni        = 1'b0;
  logic                        in_valid      = 1'b0;
  logic                        in_ready;
  logic                        func          = FUNC_WRITE;
  logic [IDX_W-1:0]            entry_index   = '0;
  logic signed [IN_VAL_W-1:0]  entry_value   = '0;
  logic signed [IN_VAL_W-1:0]  search_key    = '0;
  logic [IDX_W-1:0]            low_bound     = '0;
  logic [IDX_W-1:0]            high_bound    = '0;
  logic                        out_valid;
  logic                        out_ready     = 1'b0;
  logic signed [OUT_IDX_W-1:0] interval_index;
  logic                        below_range;
  logic                        above_range;
  logic                        bad_bounds;
  logic                        is_search;

  logic signed [IN_VAL_W-1:0] table_model [TABLE_DEPTH];
  bit                         written_model [TABLE_DEPTH];
  lookup_answer_t             pending_answers [$];
  directed_row_t              directed_rows [DIRECTED_COUNT];

  int mismatches      = 0;
  int items_sent      = 0;
  int results_checked = 0;
  int writes_seen     = 0;
  int below_seen      = 0;
  int above_seen      = 0;
  int bad_seen        = 0;
  int interior_seen   = 0;
  bit calm            = 1'b0;
  bit hold_off_done   = 1'b0;

  sorted_table_interval_search i_dut (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .in_valid_i       (in_valid),
    .in_ready_o       (in_ready),
    .func_i           (func),
    .entry_index_i    (entry_index),
    .entry_value_i    (entry_value),
    .search_key_i     (search_key),
    .low_bound_i      (low_bound),
    .high_bound_i     (high_bound),
    .out_valid_o      (out_valid),
    .out_ready_i      (out_ready),
    .interval_index_o (interval_index),
    .below_range_o    (below_range),
    .above_range_o    (above_range),
    .bad_bounds_o     (bad_bounds),
    .is_search_o      (is_search)
  );

  always #1 clk_i = ~clk_i;

  // A search that touches an entry never written is flagged so that send_search does not send it.
  function automatic logic signed [IN_VAL_W-1:0] model_entry(int unsigned idx, inout bit stray);
    if (idx >= TABLE_DEPTH) return '0;
    if (!written_model[idx]) stray = 1'b1;
    return table_model[idx];
  endfunction

  function automatic lookup_answer_t predict_answer(lookup_item_t it, output bit stray);
    lookup_answer_t ans;
    int unsigned    lo;
    int unsigned    hi;
    int unsigned    mid;
    ans   = WRITE_ACK;
    stray = 1'b0;
    if (it.func == FUNC_WRITE) begin
      if (it.entry_index < TABLE_DEPTH) begin
        table_model[it.entry_index]   = it.entry_value;
        written_model[it.entry_index] = 1'b1;
      end
      return ans;
    end
    ans.is_search = 1'b1;
    lo = it.low_bound;
    hi = it.high_bound;
    if (hi <= lo) begin
      ans.bad = 1'b1;
    end else if ($signed(it.search_key) < $signed(model_entry(lo, stray))) begin
      ans.below       = 1'b1;
      ans.found_index = OUT_IDX_W'(lo) - 1'b1;
    end else if ($signed(it.search_key) >= $signed(model_entry(hi, stray))) begin
      ans.above       = 1'b1;
      ans.found_index = OUT_IDX_W'(hi);
    end else begin
      // Moving lo on equal entries lands on the last of a run of equal values.
      mid = (lo + hi) >> 1;
      while (mid != lo) begin
        if ($signed(model_entry(mid, stray)) > $signed(it.search_key)) begin
          hi = mid;
        end else begin
          lo = mid;
        end
        mid = (lo + hi) >> 1;
      end
      ans.found_index = OUT_IDX_W'(mid);
    end
    return ans;
  endfunction

  task automatic report_mismatch(string what);
    mismatches++;
    if (mismatches <= 40) $display("%0t ns: %s", $time, what);
  endtask

  // Called at a rising edge; returns at the edge of the transfer.
  task automatic offer_item(lookup_item_t it, lookup_answer_t ans);
    if (!calm && $urandom_range(0, 4) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 13)) @(posedge clk_i);
    end
    in_valid    <= 1'b1;
    func        <= it.func;
    entry_index <= it.entry_index;
    entry_value <= it.entry_value;
    search_key  <= it.search_key;
    low_bound   <= it.low_bound;
    high_bound  <= it.high_bound;
    @(posedge clk_i);
    while (!in_ready) @(posedge clk_i);
    pending_answers.push_back(ans);
    items_sent++;
    calm = (items_sent >= ITEM_TARGET - CALM_ITEMS);
  endtask

  task automatic send_write(int unsigned idx, logic signed [IN_VAL_W-1:0] value);
    lookup_item_t it;
    lookup_answer_t ans;
    bit stray;
    it.func        = FUNC_WRITE;
    it.entry_index = IDX_W'(idx);
    it.entry_value = value;
    it.search_key  = $urandom;
    it.low_bound   = IDX_W'($urandom);
    it.high_bound  = IDX_W'($urandom);
    ans = predict_answer(it, stray);
    offer_item(it, ans);
  endtask

  task automatic send_search(logic signed [IN_VAL_W-1:0] key, int unsigned lo,
                             int unsigned hi, output bit sent);
    lookup_item_t it;
    lookup_answer_t ans;
    bit stray;
    it.func        = FUNC_SEARCH;
    it.entry_index = IDX_W'($urandom);
    it.entry_value = $urandom;
    it.search_key  = key;
    it.low_bound   = IDX_W'(lo);
    it.high_bound  = IDX_W'(hi);
    ans  = predict_answer(it, stray);
    sent = !stray;
    if (sent) offer_item(it, ans);
  endtask

  task automatic search_bad_bounds();
    int unsigned lo;
    bit sent;
    lo = $urandom_range(0, TABLE_DEPTH - 1);
    send_search($urandom, lo, $urandom_range(0, lo), sent);
  endtask

  // Random bounds anywhere; falls back to bad bounds when no candidate stays on written entries.
  task automatic search_anywhere();
    int unsigned lo;
    int unsigned hi;
    bit sent;
    sent = 1'b0;
    for (int t = 0; t < 20 && !sent; t++) begin
      lo = $urandom_range(0, TABLE_DEPTH - 2);
      if ($urandom_range(0, 3) == 0) begin
        hi = $urandom_range(lo + 1, TABLE_DEPTH - 1);
      end else begin
        hi = $urandom_range(lo + 1, (lo + 64 < TABLE_DEPTH) ? lo + 64 : TABLE_DEPTH - 1);
      end
      send_search($urandom, lo, hi, sent);
    end
    if (!sent) search_bad_bounds();
  endtask

  // Loads an ascending run into a window of the table, then searches inside it.
  task automatic write_sorted_run();
    int n;
    int base;
    int searches;
    int lo;
    int hi;
    int pick;
    int spread;
    int vals [$];
    bit sent;
    logic signed [IN_VAL_W-1:0] key;
    n = ($urandom_range(0, 9) == 0) ? $urandom_range(25, 120) : $urandom_range(2, 24);
    base = $urandom_range(0, TABLE_DEPTH - n);
    spread = $urandom_range(0, 2);
    for (int i = 0; i < n; i++) begin
      if (spread == 0) begin
        vals.push_back(int'($urandom_range(0, 4 * n)) - 2 * n);
      end else begin
        vals.push_back(int'($urandom));
      end
    end
    vals.sort();
    for (int i = 1; i < n; i++) begin
      if ($urandom_range(0, 4) == 0) vals[i] = vals[i-1];
    end
    if ($urandom_range(0, 7) == 0) vals[0] = VAL_MIN;
    if ($urandom_range(0, 7) == 0) vals[n-1] = VAL_MAX;
    for (int i = 0; i < n; i++) send_write(base + i, vals[i]);
    searches = $urandom_range(2, 12);
    for (int s = 0; s < searches; s++) begin
      lo   = $urandom_range(base, base + n - 2);
      hi   = $urandom_range(lo + 1, base + n - 1);
      key  = vals[$urandom_range(lo - base, hi - base)];
      pick = $urandom_range(0, 3);
      if (pick == 1) begin
        key = key + 1;
      end else if (pick == 2) begin
        key = key - 1;
      end else if (pick == 3) begin
        key = $urandom;
      end
      send_search(key, lo, hi, sent);
    end
  endtask

  always @(posedge clk_i) begin
    lookup_answer_t want;
    if (rst_ni && out_valid && out_ready) begin
      if (pending_answers.size() == 0) begin
        report_mismatch("result transfer with no answer outstanding");
      end else begin
        want = pending_answers.pop_front();
        results_checked++;
        if (interval_index !== want.found_index)
          report_mismatch($sformatf("result %0d: interval_index %0d, expected %0d",
                                    results_checked, interval_index, want.found_index));
        if (below_range !== want.below)
          report_mismatch($sformatf("result %0d: below_range %b, expected %b",
                                    results_checked, below_range, want.below));
        if (above_range !== want.above)
          report_mismatch($sformatf("result %0d: above_range %b, expected %b",
                                    results_checked, above_range, want.above));
        if (bad_bounds !== want.bad)
          report_mismatch($sformatf("result %0d: bad_bounds %b, expected %b",
                                    results_checked, bad_bounds, want.bad));
        if (is_search !== want.is_search)
          report_mismatch($sformatf("result %0d: is_search %b, expected %b",
                                    results_checked, is_search, want.is_search));
        if (!want.is_search) begin
          writes_seen++;
        end else if (want.bad) begin
          bad_seen++;
        end else if (want.below) begin
          below_seen++;
        end else if (want.above) begin
          above_seen++;
        end else begin
          interior_seen++;
        end
      end
    end
  end

  // Output side: random stalls, plus one long hold-off so that the input side backs up.
  initial begin
    while (!rst_ni) @(posedge clk_i);
    forever begin
      if (!hold_off_done && results_checked >= 120) begin
        out_ready <= 1'b0;
        repeat (HOLD_OFF_CYCLES) @(posedge clk_i);
        hold_off_done = 1'b1;
      end else if (!calm && $urandom_range(0, 5) == 0) begin
        out_ready <= 1'b0;
        repeat ($urandom_range(1, 13)) @(posedge clk_i);
      end else begin
        out_ready <= 1'b1;
        @(posedge clk_i);
      end
    end
  end

  initial begin
    #800_000;
    $display("sorted_table_interval_search: mismatch");
    $finish;
  end

  initial begin
    lookup_answer_t ans;
    bit stray;
    int choice;
    int drain;

    // Equal entries at 2..4, the extremes at 0 and 1023; later rows break the order.
    directed_rows[0]  = '{'{FUNC_WRITE, 10'd0, VAL_MIN, 32'sd0, 10'd0, 10'd0}, 1'b1, WRITE_ACK};
    directed_rows[1]  = '{'{FUNC_WRITE, 10'd1, -32'sd100, 32'sd0, 10'd0, 10'd0}, 1'b1, WRITE_ACK};
    directed_rows[2]  = '{'{FUNC_WRITE, 10'd2, 32'sd0, 32'sd0, 10'd0, 10'd0}, 1'b1, WRITE_ACK};
    directed_rows[3]  = '{'{FUNC_WRITE, 10'd3, 32'sd0, 32'sd0, 10'd0, 10'd0}, 1'b1, WRITE_ACK};
    directed_rows[4]  = '{'{FUNC_WRITE, 10'd4, 32'sd0, 32'sd0, 10'd0, 10'd0}, 1'b1, WRITE_ACK};
    directed_rows[5]  = '{'{FUNC_WRITE, 10'd5, 32'sd500, 32'sd0, 10'd0, 10'd0}, 1'b1, WRITE_ACK};
    directed_rows[6]  = '{'{FUNC_WRITE, 10'd1022, 32'sd1000, 32'sd0, 10'd0, 10'd0},
                          1'b1, WRITE_ACK};
    directed_rows[7]  = '{'{FUNC_WRITE, 10'd1023, VAL_MAX, 32'sd0, 10'd0, 10'd0},
                          1'b1, WRITE_ACK};
    directed_rows[8]  = '{'{FUNC_SEARCH, 10'd0, 32'sd0, 32'sd0, 10'd5, 10'd5}, 1'b1, BAD_BOUNDS};
    directed_rows[9]  = '{'{FUNC_SEARCH, 10'd0, 32'sd0, VAL_MAX, 10'd1023, 10'd0},
                          1'b1, BAD_BOUNDS};
    directed_rows[10] = '{'{FUNC_SEARCH, 10'd0, 32'sd0, VAL_MIN, 10'd1, 10'd5},
                          1'b1, '{11'sd0, 1'b1, 1'b0, 1'b0, 1'b1}};
    directed_rows[11] = '{'{FUNC_SEARCH, 10'd0, 32'sd0, VAL_MIN, 10'd0, 10'd5}, 1'b0, '0};
    directed_rows[12] = '{'{FUNC_SEARCH, 10'd0, 32'sd0, VAL_MAX, 10'd0, 10'd5},
                          1'b1, '{11'sd5, 1'b0, 1'b1, 1'b0, 1'b1}};
    directed_rows[13] = '{'{FUNC_SEARCH, 10'd0, 32'sd0, 32'sd0, 10'd0, 10'd5}, 1'b0, '0};
    directed_rows[14] = '{'{FUNC_SEARCH, 10'd0, 32'sd0, -32'sd1, 10'd0, 10'd5}, 1'b0, '0};
    directed_rows[15] = '{'{FUNC_SEARCH, 10'd0, 32'sd0, 32'sd499, 10'd2, 10'd5}, 1'b0, '0};
    directed_rows[16] = '{'{FUNC_SEARCH, 10'd0, 32'sd0, -32'sd1, 10'd2, 10'd4},
                          1'b1, '{11'sd1, 1'b1, 1'b0, 1'b0, 1'b1}};
    directed_rows[17] = '{'{FUNC_SEARCH, 10'd0, 32'sd0, VAL_MAX, 10'd1022, 10'd1023},
                          1'b1, '{11'sd1023, 1'b0, 1'b1, 1'b0, 1'b1}};
    directed_rows[18] = '{'{FUNC_SEARCH, 10'd0, 32'sd0, 32'sd1000, 10'd1022, 10'd1023},
                          1'b0, '0};
    directed_rows[19] = '{'{FUNC_WRITE, 10'd3, 32'sd900, 32'sd0, 10'd0, 10'd0}, 1'b1, WRITE_ACK};
    directed_rows[20] = '{'{FUNC_SEARCH, 10'd0, 32'sd0, 32'sd100, 10'd1, 10'd5}, 1'b0, '0};
    directed_rows[21] = '{'{FUNC_WRITE, 10'd0, VAL_MAX, 32'sd0, 10'd0, 10'd0}, 1'b1, WRITE_ACK};
    directed_rows[22] = '{'{FUNC_SEARCH, 10'd0, 32'sd0, 32'sd0, 10'd0, 10'd5},
                          1'b1, '{-11'sd1, 1'b1, 1'b0, 1'b0, 1'b1}};

    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;

    for (int r = 0; r < DIRECTED_COUNT; r++) begin
      ans = predict_answer(directed_rows[r].item, stray);
      offer_item(directed_rows[r].item, directed_rows[r].typed ? directed_rows[r].answer : ans);
    end

    while (items_sent < ITEM_TARGET) begin
      choice = $urandom_range(0, 99);
      if (choice < 55) begin
        write_sorted_run();
      end else if (choice < 70) begin
        send_write($urandom_range(0, TABLE_DEPTH - 1), $urandom);
      end else if (choice < 85) begin
        search_anywhere();
      end else begin
        search_bad_bounds();
      end
    end
    in_valid <= 1'b0;

    drain = 0;
    while (pending_answers.size() != 0 && drain < 2000) begin
      @(posedge clk_i);
      drain++;
    end
    repeat (20) @(posedge clk_i);
    if (pending_answers.size() != 0)
      report_mismatch($sformatf("%0d answers never arrived", pending_answers.size()));

    $display("Run covered %0d items: %0d table writes; searches %0d below range,",
             items_sent, writes_seen, below_seen);
    $display("  %0d above range, %0d bad bounds, %0d inside; %0d-cycle output hold-off.",
             above_seen, bad_seen, interior_seen, HOLD_OFF_CYCLES);
    if (mismatches == 0) begin
      $display("sorted_table_interval_search: match");
    end else begin
      $display("sorted_table_interval_search: mismatch");
    end
    $finish;
  end

endmodule

### filelist.f
hdl/sts_pkg.sv
hdl/sts_ram.sv
hdl/sts_core.sv
hdl/sorted_table_interval_search.sv
tb/sv/sorted_table_interval_search_tb.sv
